### src/lcab_pkg.sv
// lcab_pkg: shared widths, request codes and sequencer states for the
// binary-lifting lowest-common-ancestor engine. no dependencies.
`timescale 1ns / 1ps

package lcab_pkg;

   localparam int ID_W  = 10;
   localparam int CMD_W = 2;

   // request codes
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B_RD1,
      ST_B_RD2,
      ST_B_WR,
      ST_Q_DEPTH,
      ST_Q_LIFT,
      ST_Q_LIFT_WT,
      ST_Q_CHECK,
      ST_Q_CLIMB,
      ST_Q_CLIMB_WT,
      ST_Q_FINAL,
      ST_Q_FINAL_WT
   } state_type;

endpackage

### src/lca_binary_lifting.sv
// lca_binary_lifting: lowest common ancestor engine, jump table and depth store in
// synchronous memories with two registered read ports. depends on lcab_pkg.
// load: busy never rises. build: busy for the whole table walk, no result. query: busy
// through the lift and the climb, which is skipped when the lift lands on the other node;
// result strobes in the same cycle busy falls, a bad id the cycle after its request; no
// stall. sync reset clears sequencer, node_count to 1.
`timescale 1ns / 1ps

module lca_binary_lifting #(
   parameter int LEVELS    = 10,
   parameter int MAX_NODES = 1023
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       start,
   output logic                       busy,
   input  logic [lcab_pkg::CMD_W-1:0] req_cmd,
   input  logic [lcab_pkg::ID_W-1:0]  req_node_id,
   input  logic [lcab_pkg::ID_W-1:0]  req_parent_id,
   input  logic [lcab_pkg::ID_W-1:0]  req_node_level,
   input  logic [lcab_pkg::ID_W-1:0]  req_query_u,
   input  logic [lcab_pkg::ID_W-1:0]  req_query_v,
   // result channel
   output logic                       rsp_valid,
   output logic [lcab_pkg::ID_W-1:0]  rsp_ancestor,
   output logic                       rsp_bad_query,
   // configuration
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lcab_pkg::ID_W-1:0]  csr_node_count
);

   import lcab_pkg::*;

   localparam int ID_MAX   = (1 << ID_W) - 1;
   localparam int ID_LIMIT = (MAX_NODES < ID_MAX) ? MAX_NODES : ID_MAX;
   localparam int DEPTH    = ID_LIMIT + 1;
   localparam int AW       = $clog2(DEPTH);
   localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int JAW      = LW + AW;
   localparam int JT_SIZE  = LEVELS << AW;

   function automatic logic over_max(input logic [ID_W-1:0] id);
      over_max = 32'(id) > MAX_NODES;
   endfunction

   function automatic logic [JAW-1:0] jt_addr(input logic [LW-1:0] l,
                                              input logic [ID_W-1:0] n);
      jt_addr = {l, n[AW-1:0]};
   endfunction

   // memories
   logic [ID_W-1:0] jt_mem [JT_SIZE];
   logic [ID_W-1:0] dp_mem [DEPTH];

   state_type       state_ff, state_in;
   logic [LW-1:0]   lvl_ff, lvl_in;
   logic [ID_W-1:0] nd_ff, nd_in;
   logic [ID_W-1:0] u_ff, u_in;
   logic [ID_W-1:0] v_ff, v_in;
   logic [LEVELS-1:0] diff_ff, diff_in;
   logic [ID_W-1:0] node_count_ff, node_count_in;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_ancestor_ff, rsp_ancestor_in;
   logic            rsp_bad_ff, rsp_bad_in;

   logic [JAW-1:0]  jt_ra, jt_rb, jt_wa;
   logic            jt_we;
   logic [ID_W-1:0] jt_wd;
   logic [ID_W-1:0] ja_rd_ff, jb_rd_ff;
   logic            za_ff, za_in, zb_ff, zb_in;

   logic [AW-1:0]   dp_ra, dp_rb, dp_wa;
   logic            dp_we;
   logic [ID_W-1:0] dp_wd;
   logic [ID_W-1:0] dpa_rd_ff, dpb_rd_ff;

   logic [ID_W-1:0] cnt;
   logic [ID_W-1:0] hop_a, hop_b;
   logic            accept, query_bad;

   assign cnt = over_max(node_count_ff) ? ID_W'(MAX_NODES) : node_count_ff;
   // a read through an id beyond the table yields 0
   assign hop_a = za_ff ? '0 : ja_rd_ff;
   assign hop_b = zb_ff ? '0 : jb_rd_ff;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign query_bad = (req_query_u == '0) || (req_query_v == '0) ||
                      (req_query_u > cnt) || (req_query_v > cnt);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ancestor  = rsp_ancestor_ff;
   assign rsp_bad_query = rsp_bad_ff;

   always_ff @(posedge clock) begin
      if (jt_we) begin
         jt_mem[jt_wa] <= jt_wd;
      end
      ja_rd_ff <= jt_mem[jt_ra];
      jb_rd_ff <= jt_mem[jt_rb];
   end

   always_ff @(posedge clock) begin
      if (dp_we) begin
         dp_mem[dp_wa] <= dp_wd;
      end
      dpa_rd_ff <= dp_mem[dp_ra];
      dpb_rd_ff <= dp_mem[dp_rb];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lvl_ff        <= '0;
         node_count_ff <= ID_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lvl_ff        <= lvl_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nd_ff           <= nd_in;
      u_ff            <= u_in;
      v_ff            <= v_in;
      diff_ff         <= diff_in;
      za_ff           <= za_in;
      zb_ff           <= zb_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
      rsp_bad_ff      <= rsp_bad_in;
   end

   always_comb begin
      state_in        = state_ff;
      lvl_in          = lvl_ff;
      nd_in           = nd_ff;
      u_in            = u_ff;
      v_in            = v_ff;
      diff_in         = diff_ff;
      node_count_in   = node_count_ff;
      rsp_valid_in    = 1'b0;
      rsp_ancestor_in = rsp_ancestor_ff;
      rsp_bad_in      = rsp_bad_ff;
      jt_ra           = '0;
      jt_rb           = '0;
      za_in           = 1'b0;
      zb_in           = 1'b0;
      jt_we           = 1'b0;
      jt_wa           = '0;
      jt_wd           = '0;
      dp_ra           = '0;
      dp_rb           = '0;
      dp_we           = 1'b0;
      dp_wa           = '0;
      dp_wd           = '0;

      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_cmd)
                  CMD_LOAD: begin
                     if (!over_max(req_node_id)) begin
                        jt_we = 1'b1;
                        jt_wa = jt_addr('0, req_node_id);
                        jt_wd = req_parent_id;
                        dp_we = 1'b1;
                        dp_wa = req_node_id[AW-1:0];
                        dp_wd = req_node_level;
                     end
                  end
                  CMD_BUILD: begin
                     if (cnt != '0 && LEVELS > 1) begin
                        lvl_in   = LW'(1);
                        nd_in    = ID_W'(1);
                        state_in = ST_B_RD1;
                     end
                  end
                  CMD_QUERY: begin
                     if (query_bad) begin
                        rsp_valid_in    = 1'b1;
                        rsp_ancestor_in = '0;
                        rsp_bad_in      = 1'b1;
                     end else begin
                        u_in     = req_query_u;
                        v_in     = req_query_v;
                        dp_ra    = req_query_u[AW-1:0];
                        dp_rb    = req_query_v[AW-1:0];
                        state_in = ST_Q_DEPTH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // build: entry(l, n) = hop(l-1, hop(l-1, n))
         ST_B_RD1: begin
            jt_ra    = jt_addr(lvl_ff - LW'(1), nd_ff);
            za_in    = over_max(nd_ff);
            state_in = ST_B_RD2;
         end
         ST_B_RD2: begin
            jt_ra    = jt_addr(lvl_ff - LW'(1), hop_a);
            za_in    = over_max(hop_a);
            state_in = ST_B_WR;
         end
         ST_B_WR: begin
            jt_we = 1'b1;
            jt_wa = jt_addr(lvl_ff, nd_ff);
            jt_wd = hop_a;
            if (nd_ff == cnt) begin
               nd_in = ID_W'(1);
               if (lvl_ff == LW'(LEVELS - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  lvl_in   = lvl_ff + LW'(1);
                  state_in = ST_B_RD1;
               end
            end else begin
               nd_in    = nd_ff + ID_W'(1);
               state_in = ST_B_RD1;
            end
         end
         // keep u the shallower node
         ST_Q_DEPTH: begin
            if (dpa_rd_ff > dpb_rd_ff) begin
               u_in    = v_ff;
               v_in    = u_ff;
               diff_in = LEVELS'(dpa_rd_ff - dpb_rd_ff);
            end else begin
               diff_in = LEVELS'(dpb_rd_ff - dpa_rd_ff);
            end
            lvl_in   = LW'(LEVELS - 1);
            state_in = ST_Q_LIFT;
         end
         ST_Q_LIFT: begin
            if (diff_ff[LEVELS-1]) begin
               jt_ra    = jt_addr(lvl_ff, v_ff);
               za_in    = over_max(v_ff);
               state_in = ST_Q_LIFT_WT;
            end else begin
               diff_in = diff_ff << 1;
               if (lvl_ff == '0) begin
                  state_in = ST_Q_CHECK;
               end else begin
                  lvl_in = lvl_ff - LW'(1);
               end
            end
         end
         ST_Q_LIFT_WT: begin
            v_in    = hop_a;
            diff_in = diff_ff << 1;
            if (lvl_ff == '0) begin
               state_in = ST_Q_CHECK;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = ST_Q_LIFT;
            end
         end
         ST_Q_CHECK: begin
            if (u_ff == v_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_ancestor_in = u_ff;
               rsp_bad_in      = 1'b0;
               state_in        = ST_IDLE;
            end else begin
               lvl_in   = LW'(LEVELS - 1);
               state_in = ST_Q_CLIMB;
            end
         end
         ST_Q_CLIMB: begin
            jt_ra    = jt_addr(lvl_ff, u_ff);
            jt_rb    = jt_addr(lvl_ff, v_ff);
            za_in    = over_max(u_ff);
            zb_in    = over_max(v_ff);
            state_in = ST_Q_CLIMB_WT;
         end
         ST_Q_CLIMB_WT: begin
            if (hop_a != hop_b) begin
               u_in = hop_a;
               v_in = hop_b;
            end
            if (lvl_ff == '0) begin
               state_in = ST_Q_FINAL;
            end else begin
               lvl_in   = lvl_ff - LW'(1);
               state_in = ST_Q_CLIMB;
            end
         end
         ST_Q_FINAL: begin
            jt_ra    = jt_addr('0, u_ff);
            za_in    = over_max(u_ff);
            state_in = ST_Q_FINAL_WT;
         end
         ST_Q_FINAL_WT: begin
            rsp_valid_in    = 1'b1;
            rsp_ancestor_in = hop_a;
            rsp_bad_in      = 1'b0;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a result only follows a query request or the end of a query walk
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_Q_CHECK || state_ff == ST_Q_FINAL_WT ||
                          (accept && req_cmd == CMD_QUERY)))
      else $error("result without a query");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobed while sequencer still busy");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_query |-> rsp_ancestor == '0)
      else $error("bad query carries an ancestor");

   // build never rewrites the parent level
   a_build_level: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_RD1 || state_ff == ST_B_RD2 || state_ff == ST_B_WR)
         |-> lvl_ff != '0)
      else $error("build walking level zero");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      dp_we |-> state_ff == ST_IDLE)
      else $error("depth write outside a load");

endmodule

### test/tb_lca_binary_lifting.sv
// tb_lca_binary_lifting: self-checking bench for the binary-lifting lca engine,
// with directed probes, random trees of many sizes, queries and table rebuilds.
// depends on lcab_pkg and lca_binary_lifting.
`timescale 1ns / 1ps

module tb_lca_binary_lifting;
   import lcab_pkg::*;

   localparam int LEVELS       = 10;
   localparam int MAX_NODES    = 1023;
   localparam int CLK_HALF     = 4;
   localparam int REQUEST_GOAL = 1850;
   localparam int QUIET_CYCLES = 4 * LEVELS + 16;
   localparam int STALL_LIMIT  = 4 * 3 * (LEVELS - 1) * (MAX_NODES + 1) + 4096;
   localparam int NPROBE       = 17;
   localparam int MAX_SHOWN    = 40;

   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0] ancestor;
      logic            bad;
   } lca_answer_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  node_id;
      logic [ID_W-1:0]  parent_id;
      logic [ID_W-1:0]  node_level;
      logic [ID_W-1:0]  query_u;
      logic [ID_W-1:0]  query_v;
      logic             stated;
      logic [ID_W-1:0]  ancestor;
      logic             bad;
   } probe_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd;
   logic [ID_W-1:0]   req_node_id;
   logic [ID_W-1:0]   req_parent_id;
   logic [ID_W-1:0]   req_node_level;
   logic [ID_W-1:0]   req_query_u;
   logic [ID_W-1:0]   req_query_v;
   logic              rsp_valid;
   logic [ID_W-1:0]   rsp_ancestor;
   logic              rsp_bad_query;
   logic              csr_valid;
   logic              csr_ready;
   logic [ID_W-1:0]   csr_node_count;

   // expectation typed into the probe table, travels with its request
   logic              stated_valid;
   lca_answer_type    stated_answer;

   // predictor state
   logic [ID_W-1:0]   hop_mem [LEVELS][MAX_NODES+1];
   logic [ID_W-1:0]   depth_mem [MAX_NODES+1];
   logic [ID_W-1:0]   model_count;

   lca_answer_type    answers_due [$];
   probe_row_type     probes [NPROBE];
   int                error_count;
   int                stall_cycles;
   int                sent;
   int                gap_pct;
   logic [CMD_W-1:0]  last_cmd;

   lca_binary_lifting #(
      .LEVELS   (LEVELS),
      .MAX_NODES(MAX_NODES)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_node_id   (req_node_id),
      .req_parent_id (req_parent_id),
      .req_node_level(req_node_level),
      .req_query_u   (req_query_u),
      .req_query_v   (req_query_v),
      .rsp_valid     (rsp_valid),
      .rsp_ancestor  (rsp_ancestor),
      .rsp_bad_query (rsp_bad_query),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_node_count(csr_node_count)
   );

   initial clock = 1'b0;
   always #(CLK_HALF) clock = ~clock;

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (error_count < MAX_SHOWN)
         $display("ERROR at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic [ID_W-1:0] pick_id(input int lo, input int hi);
      return ID_W'($urandom_range(hi, lo));
   endfunction

   // id that a query must reject, or that a load may write without harm
   function automatic logic [ID_W-1:0] stray_id(input int count);
      if (count >= MAX_NODES || $urandom_range(1) == 0)
         return '0;
      return pick_id(count + 1, MAX_NODES);
   endfunction

   function automatic lca_answer_type solve_lca(input logic [ID_W-1:0] qa,
                                                input logic [ID_W-1:0] qb);
      lca_answer_type  res;
      logic [ID_W-1:0] lo, hi, na, nb, gap;
      int              lvl, limit;
      limit = (model_count > MAX_NODES) ? MAX_NODES : int'(model_count);
      res.ancestor = '0;
      res.bad = 1'b1;
      if (qa == 0 || qb == 0 || qa > limit || qb > limit)
         return res;
      if (depth_mem[qa] > depth_mem[qb]) begin
         lo = qb;
         hi = qa;
      end else begin
         lo = qa;
         hi = qb;
      end
      gap = depth_mem[hi] - depth_mem[lo];
      for (lvl = LEVELS - 1; lvl >= 0; lvl--)
         if (((gap >> lvl) & 1) != 0)
            hi = hop_mem[lvl][hi];
      if (lo != hi) begin
         for (lvl = LEVELS - 1; lvl >= 0; lvl--) begin
            na = hop_mem[lvl][lo];
            nb = hop_mem[lvl][hi];
            if (na != nb) begin
               lo = na;
               hi = nb;
            end
         end
         lo = hop_mem[0][lo];
      end
      res.ancestor = lo;
      res.bad = 1'b0;
      return res;
   endfunction

   // request acceptance, predictor update, result check and activity count
   always @(posedge clock) begin : watch
      lca_answer_type due;
      int             limit, lvl, nd;
      bit             moved;
      moved = 1'b0;
      if (reset === 1'b0) begin
         if (csr_valid && csr_ready === 1'b1) begin
            model_count = csr_node_count;
            moved = 1'b1;
         end
         if (start && busy === 1'b0) begin
            moved = 1'b1;
            case (req_cmd)
               CMD_LOAD: begin
                  hop_mem[0][req_node_id] = req_parent_id;
                  depth_mem[req_node_id] = req_node_level;
               end
               CMD_BUILD: begin
                  limit = (model_count > MAX_NODES) ? MAX_NODES : int'(model_count);
                  for (lvl = 1; lvl < LEVELS; lvl++)
                     for (nd = 1; nd <= limit; nd++)
                        hop_mem[lvl][nd] = hop_mem[lvl-1][hop_mem[lvl-1][nd]];
               end
               CMD_QUERY: begin
                  if (stated_valid)
                     answers_due = {answers_due, stated_answer};
                  else
                     answers_due = {answers_due, solve_lca(req_query_u, req_query_v)};
               end
               default: ;
            endcase
         end
         if (rsp_valid === 1'b1) begin
            moved = 1'b1;
            if (answers_due.size() == 0) begin
               flag_mismatch("result with no query waiting, ancestor", rsp_ancestor, 0);
            end else begin
               due = answers_due.pop_front();
               if (rsp_ancestor !== due.ancestor)
                  flag_mismatch("ancestor", rsp_ancestor, due.ancestor);
               if (rsp_bad_query !== due.bad)
                  flag_mismatch("bad_query", rsp_bad_query, due.bad);
            end
         end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // leaves start high on return; anything that waits afterwards lowers it first
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] nid,
                               input logic [ID_W-1:0] par, input logic [ID_W-1:0] lvl,
                               input logic [ID_W-1:0] qu, input logic [ID_W-1:0] qv,
                               input logic stated, input lca_answer_type answer);
      int gap;
      if (sent < REQUEST_GOAL * 9 / 10 && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(11, 1);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_node_id    <= nid;
      req_parent_id  <= par;
      req_node_level <= lvl;
      req_query_u    <= qu;
      req_query_v    <= qv;
      stated_valid   <= stated;
      stated_answer  <= answer;
      do @(posedge clock); while (busy !== 1'b0);
      last_cmd = cmd;
      if (cmd != CMD_SPARE)
         sent++;
   endtask

   task automatic load_node(input logic [ID_W-1:0] id, input logic [ID_W-1:0] par,
                            input logic [ID_W-1:0] lvl);
      send_request(CMD_LOAD, id, par, lvl, pick_id(0, MAX_NODES), pick_id(0, MAX_NODES),
                   1'b0, '0);
   endtask

   task automatic ask_lca(input logic [ID_W-1:0] qu, input logic [ID_W-1:0] qv);
      send_request(CMD_QUERY, pick_id(0, MAX_NODES), pick_id(0, MAX_NODES),
                   pick_id(1, MAX_NODES), qu, qv, 1'b0, '0);
   endtask

   task automatic build_jumps();
      send_request(CMD_BUILD, pick_id(0, MAX_NODES), pick_id(0, MAX_NODES),
                   pick_id(1, MAX_NODES), pick_id(0, MAX_NODES), pick_id(0, MAX_NODES),
                   1'b0, '0);
   endtask

   // unused command, or a load to node 0 or beyond the nodes in use
   task automatic stray_request(input int count);
      if ($urandom_range(2) == 0)
         send_request(CMD_SPARE, pick_id(0, MAX_NODES), pick_id(0, MAX_NODES),
                      pick_id(1, MAX_NODES), pick_id(0, MAX_NODES), pick_id(0, MAX_NODES),
                      1'b0, '0);
      else
         load_node(stray_id(count), pick_id(0, MAX_NODES), pick_id(1, MAX_NODES));
   endtask

   task automatic wait_answers();
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
   endtask

   // a build gives no result, so allow for one still running
   task automatic settle();
      int extra;
      wait_answers();
      extra = QUIET_CYCLES;
      if (last_cmd == CMD_BUILD)
         extra += 3 * (LEVELS - 1) * int'(model_count);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_count(input logic [ID_W-1:0] value);
      settle();
      csr_valid      <= 1'b1;
      csr_node_count <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   // load a random tree over ids 1..count, build, then query it
   task automatic run_phase(input int count, input bit noisy, input int queries);
      int              order[];
      int              tdepth[];
      int              k, j, tmp, spread, roll;
      logic [ID_W-1:0] par, lvl;
      write_count(ID_W'(count));
      gap_pct = ($urandom_range(2) == 0) ? 0 : 25;
      order = new[count + 1];
      tdepth = new[count + 1];
      for (k = 0; k < count; k++)
         order[k] = k + 1;
      for (k = count - 1; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      // small spread gives deep chains, large spread gives bushy trees
      spread = $urandom_range(count);
      for (k = 0; k < count; k++) begin
         if (k == 0) begin
            par = ID_W'(order[0]);
            tdepth[order[0]] = 1;
         end else begin
            j = k - 1 - $urandom_range((spread < k - 1) ? spread : k - 1);
            par = ID_W'(order[j]);
            tdepth[order[k]] = tdepth[order[j]] + 1;
         end
         lvl = ID_W'(tdepth[order[k]]);
         if (noisy) begin
            par = pick_id(1, count);
            lvl = pick_id(1, MAX_NODES);
         end
         load_node(ID_W'(order[k]), par, lvl);
         if ($urandom_range(15) == 0)
            stray_request(count);
      end
      build_jumps();
      for (k = 0; k < queries; k++) begin
         roll = $urandom_range(99);
         if (roll < 8 || count == 0) begin
            case ($urandom_range(2))
               0: ask_lca(stray_id(count), (count == 0) ? '0 : pick_id(1, count));
               1: ask_lca((count == 0) ? '0 : pick_id(1, count), stray_id(count));
               default: ask_lca(stray_id(count), stray_id(count));
            endcase
         end else if (roll < 12) begin
            load_node(pick_id(1, count), pick_id(1, count), pick_id(1, MAX_NODES));
            if ($urandom_range(1) == 0)
               build_jumps();
         end else if (roll < 14) begin
            stray_request(count);
         end else if (roll < 16) begin
            wait_answers();
         end else begin
            ask_lca(pick_id(1, count), pick_id(1, count));
         end
      end
   endtask

   initial begin
      int lvl, nd;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_cmd        <= CMD_LOAD;
      req_node_id    <= '0;
      req_parent_id  <= '0;
      req_node_level <= '0;
      req_query_u    <= '0;
      req_query_v    <= '0;
      csr_valid      <= 1'b0;
      csr_node_count <= '0;
      stated_valid   <= 1'b0;
      stated_answer  <= '0;
      error_count  = 0;
      stall_cycles = 0;
      sent         = 0;
      gap_pct      = 20;
      last_cmd     = CMD_LOAD;
      model_count  = 1;
      for (lvl = 0; lvl < LEVELS; lvl++)
         for (nd = 0; nd <= MAX_NODES; nd++)
            hop_mem[lvl][nd] = '0;
      for (nd = 0; nd <= MAX_NODES; nd++)
         depth_mem[nd] = '0;

      // one node in use after reset; node 1 is read only once it is loaded
      probes = '{
         '{CMD_QUERY, 10'd0,    10'd0,    10'd1,    10'd0,    10'd0,    1'b1, 10'd0, 1'b1},
         '{CMD_QUERY, 10'd1023, 10'd1023, 10'd1023, 10'd0,    10'd1023, 1'b1, 10'd0, 1'b1},
         '{CMD_QUERY, 10'd0,    10'd0,    10'd1,    10'd1023, 10'd0,    1'b1, 10'd0, 1'b1},
         '{CMD_QUERY, 10'd0,    10'd0,    10'd1,    10'd1,    10'd2,    1'b1, 10'd0, 1'b1},
         '{CMD_LOAD,  10'd1023, 10'd0,    10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0},
         '{CMD_LOAD,  10'd0,    10'd1023, 10'd1,    10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
         '{CMD_LOAD,  10'd1,    10'd1,    10'd1,    10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
         '{CMD_SPARE, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0},
         '{CMD_BUILD, 10'd0,    10'd0,    10'd1,    10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
         '{CMD_QUERY, 10'd0,    10'd0,    10'd1,    10'd1,    10'd1,    1'b1, 10'd1, 1'b0},
         '{CMD_LOAD,  10'd2,    10'd1,    10'd2,    10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
         '{CMD_LOAD,  10'd3,    10'd2,    10'd3,    10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
         '{CMD_BUILD, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0},
         '{CMD_QUERY, 10'd0,    10'd0,    10'd1,    10'd1,    10'd1,    1'b0, 10'd0, 1'b0},
         '{CMD_QUERY, 10'd0,    10'd0,    10'd1,    10'd1,    10'd3,    1'b1, 10'd0, 1'b1},
         '{CMD_SPARE, 10'd0,    10'd0,    10'd1,    10'd0,    10'd0,    1'b0, 10'd0, 1'b0},
         '{CMD_QUERY, 10'd1023, 10'd1023, 10'd1023, 10'd1,    10'd1023, 1'b1, 10'd0, 1'b1}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (nd = 0; nd < NPROBE; nd++)
         send_request(probes[nd].cmd, probes[nd].node_id, probes[nd].parent_id,
                      probes[nd].node_level, probes[nd].query_u, probes[nd].query_v,
                      probes[nd].stated, '{probes[nd].ancestor, probes[nd].bad});
      wait_answers();

      run_phase(2, 1'b0, 30);
      run_phase(0, 1'b0, 15);
      run_phase(1, 1'b0, 20);
      run_phase(MAX_NODES, 1'b0, 100);
      while (sent < REQUEST_GOAL)
         run_phase($urandom_range(60, 3), $urandom_range(4) == 0, $urandom_range(60, 20));

      settle();
      if (answers_due.size() != 0)
         flag_mismatch("queries left without a result", answers_due.size(), 0);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
